### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// Each use expects signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OIE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define OIE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define OIE_ASSERT_IMP(label, ante, cons)
`define OIE_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/oie_pkg.sv
// ----------------------------------------------------------------------------
// Image expander package
// Shared codes, constants and the run descriptor type.
// ----------------------------------------------------------------------------
package oie_pkg;

  localparam logic OP_BEGIN  = 1'b0;
  localparam logic OP_BITMAP = 1'b1;

  localparam logic CFG_COLUMN_OFFSET = 1'b0;
  localparam logic CFG_ROW_OFFSET    = 1'b1;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] ADDR_HIGH_BYTE   = 8'h00;

  localparam logic [3:0] SETUP_LAST_IDX = 4'd10;
  localparam logic [3:0] PIXELS_PER_BYTE = 4'd8;

  // One decoded input word, ready to be serialized into output bytes.
  typedef struct packed {
    logic        is_setup;
    logic [3:0]  last_idx;
    logic        image_done;
    logic [7:0]  col_start;
    logic [7:0]  col_end;
    logic [7:0]  row_start;
    logic [7:0]  row_end;
    logic [7:0]  bits;
    logic [15:0] fore;
    logic [15:0] back;
  } run_t;

endpackage

### rtl/oie_frontend.sv
// ----------------------------------------------------------------------------
// Image expander front end
// Holds configuration and image state, and decodes each accepted input word
// into a run descriptor for the serializer.
// ----------------------------------------------------------------------------
module oie_frontend
  import oie_pkg::*;
#(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        accept,
  input  logic        opcode,
  input  logic [7:0]  win_x,
  input  logic [7:0]  win_y,
  input  logic [7:0]  win_width,
  input  logic [7:0]  win_height,
  input  logic [15:0] fore_color,
  input  logic [15:0] back_color,
  input  logic [7:0]  bitmap_byte,
  output logic        run_start,
  output run_t        run_desc
);

  localparam logic [8:0] PanelW = 9'(PANEL_WIDTH);
  localparam logic [8:0] PanelH = 9'(PANEL_HEIGHT);

  logic [7:0]  col_offset_r, row_offset_r;
  logic        active_r, active_nxt;
  logic [15:0] pixels_left_r, pixels_left_nxt;
  logic [15:0] fore_r, back_r;

  logic [8:0]  x_end, y_end;
  logic        win_ok;
  logic [3:0]  npix;
  logic [2:0]  npix_m1;
  logic        pix_ok;

  assign x_end  = {1'b0, win_x} + {1'b0, win_width} - 9'd1;
  assign y_end  = {1'b0, win_y} + {1'b0, win_height} - 9'd1;
  assign win_ok = (win_width != 8'd0) && (win_height != 8'd0) &&
                  (x_end < PanelW) && (y_end < PanelH);

  assign pix_ok  = active_r && (pixels_left_r != 16'd0);
  assign npix    = (pixels_left_r >= 16'(PIXELS_PER_BYTE)) ? PIXELS_PER_BYTE
                                                           : pixels_left_r[3:0];
  assign npix_m1 = 3'(npix - 4'd1);

  always_comb begin
    active_nxt      = active_r;
    pixels_left_nxt = pixels_left_r;
    run_start       = 1'b0;
    run_desc.is_setup   = (opcode == OP_BEGIN);
    run_desc.col_start  = win_x + col_offset_r;
    run_desc.col_end    = x_end[7:0] + col_offset_r;
    run_desc.row_start  = win_y + row_offset_r;
    run_desc.row_end    = y_end[7:0] + row_offset_r;
    run_desc.bits       = bitmap_byte;
    run_desc.fore       = fore_r;
    run_desc.back       = back_r;
    run_desc.last_idx   = {npix_m1, 1'b1};
    run_desc.image_done = (pixels_left_r <= 16'(PIXELS_PER_BYTE));
    if (opcode == OP_BEGIN) begin
      run_desc.last_idx   = SETUP_LAST_IDX;
      run_desc.image_done = 1'b0;
      active_nxt          = win_ok;
      run_start           = win_ok;
      if (win_ok) begin
        pixels_left_nxt = 16'(win_width) * 16'(win_height);
      end
    end else begin
      run_start = pix_ok;
      if (pix_ok) begin
        pixels_left_nxt = pixels_left_r - 16'(npix);
        active_nxt      = !run_desc.image_done;
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_offset_r  <= '0;
      row_offset_r  <= '0;
      active_r      <= 1'b0;
      pixels_left_r <= '0;
      fore_r        <= '0;
      back_r        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COLUMN_OFFSET) begin
          col_offset_r <= cfg_wdata;
        end else begin
          row_offset_r <= cfg_wdata;
        end
      end
      if (accept) begin
        active_r      <= active_nxt;
        pixels_left_r <= pixels_left_nxt;
        if (opcode == OP_BEGIN && win_ok) begin
          fore_r <= fore_color;
          back_r <= back_color;
        end
      end
    end
  end

endmodule

### rtl/oie_serializer.sv
// ----------------------------------------------------------------------------
// Image expander serializer
// Holds one run descriptor and walks it out one byte per cycle into the
// output register, while the downstream ready lets that register load.
// ----------------------------------------------------------------------------
module oie_serializer
  import oie_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  run_t       run_in,
  output logic       ready,
  output logic       run_valid,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last_of_run,
  output logic       out_image_done
);

  run_t       run_r;
  logic       run_valid_r;
  logic [3:0] idx_r;
  logic       out_valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       is_data_r, is_data_nxt;
  logic       last_r, done_r;

  logic        load, advance, run_last;
  logic [15:0] colour;

  assign load     = !out_valid_r || out_ready;
  assign advance  = run_valid_r && load;
  assign run_last = (idx_r == run_r.last_idx);
  assign ready    = !run_valid_r || (load && run_last);

  assign colour = run_r.bits[idx_r[3:1]] ? run_r.fore : run_r.back;

  always_comb begin
    byte_nxt    = idx_r[0] ? colour[15:8] : colour[7:0];
    is_data_nxt = 1'b1;
    if (run_r.is_setup) begin
      case (idx_r)
        4'd0: begin
          byte_nxt    = CMD_COLUMN_SET;
          is_data_nxt = 1'b0;
        end
        4'd2:    byte_nxt = run_r.col_start;
        4'd4:    byte_nxt = run_r.col_end;
        4'd5: begin
          byte_nxt    = CMD_ROW_SET;
          is_data_nxt = 1'b0;
        end
        4'd7:    byte_nxt = run_r.row_start;
        4'd9:    byte_nxt = run_r.row_end;
        4'd10: begin
          byte_nxt    = CMD_MEMORY_WRITE;
          is_data_nxt = 1'b0;
        end
        default: byte_nxt = ADDR_HIGH_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (load) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        run_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (advance) begin
        idx_r <= idx_r + 4'd1;
        if (run_last) begin
          run_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_r <= run_in;
    end
    if (advance) begin
      byte_r    <= byte_nxt;
      is_data_r <= is_data_nxt;
      last_r    <= run_last;
      done_r    <= run_last && run_r.image_done;
    end
  end

  assign run_valid       = run_valid_r;
  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_is_data     = is_data_r;
  assign out_last_of_run = last_r;
  assign out_image_done  = done_r;

endmodule

### rtl/one_bit_image_expander.sv
// ----------------------------------------------------------------------------
// One-bit image expander
// Turns window commands and packed monochrome bitmap words into a 16-bit
// color byte stream for a serial display controller.
// ----------------------------------------------------------------------------
// The block sends one byte per cycle from its output register while the
// downstream ready is high. A begin word whose window fits the panel yields
// eleven setup bytes; a bitmap word yields two bytes per pixel, up to sixteen
// bytes; a word that yields nothing starts no run. The next word is accepted
// in the cycle the previous word's last byte moves into the output register,
// so the sustained rate is set by the output register's one-byte-per-cycle
// drain together with the downstream ready.
`include "assert_macros.svh"

module one_bit_image_expander
  import oie_pkg::*;
#(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_win_x,
  input  logic [7:0]  in_win_y,
  input  logic [7:0]  in_win_width,
  input  logic [7:0]  in_win_height,
  input  logic [15:0] in_fore_color,
  input  logic [15:0] in_back_color,
  input  logic [7:0]  in_bitmap_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last_of_run,
  output logic        out_image_done
);

  logic accept;
  logic run_start;
  logic run_valid;
  run_t run_desc;

  assign accept = in_valid && in_ready;

  oie_frontend #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_frontend (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .opcode     (in_opcode),
    .win_x      (in_win_x),
    .win_y      (in_win_y),
    .win_width  (in_win_width),
    .win_height (in_win_height),
    .fore_color (in_fore_color),
    .back_color (in_back_color),
    .bitmap_byte(in_bitmap_byte),
    .run_start  (run_start),
    .run_desc   (run_desc)
  );

  oie_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (accept && run_start),
    .run_in         (run_desc),
    .ready          (in_ready),
    .run_valid      (run_valid),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_data    (out_is_data),
    .out_last_of_run(out_last_of_run),
    .out_image_done (out_image_done)
  );

  // With no run pending the serializer must never stall the input.
  `OIE_ASSERT_IMP(a_ready_when_empty, !run_valid, in_ready)
  // The end of an image is always a data byte that closes its word.
  `OIE_ASSERT_IMP(a_done_is_last, out_valid && out_image_done,
                  out_last_of_run && out_is_data)
  // Command bytes are only the three window commands.
  `OIE_ASSERT_IMP(a_cmd_codes, out_valid && !out_is_data,
                  out_byte == CMD_COLUMN_SET || out_byte == CMD_ROW_SET ||
                  out_byte == CMD_MEMORY_WRITE)
  // A word that starts a run leaves a run pending in the next cycle.
  `OIE_ASSERT_NXT(a_run_loaded, accept && run_start, run_valid)

endmodule

### tb/sv/tb_one_bit_image_expander.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// One-bit image expander testbench
// Sends window-begin and packed bitmap words into the expander. Each accepted
// word is run through a behavioral model of the display byte stream, and
// every byte the block emits is compared against the queue that model fills.
// A short table of directed words comes first. Random images follow, with random
// gaps and stalls in all but one phase, under several panel offset settings.
// ----------------------------------------------------------------------------
module tb_one_bit_image_expander;
  import oie_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int PANEL_W        = 128;
  localparam int PANEL_H        = 160;
  localparam int RANDOM_WORDS   = 320;
  localparam int PHASES         = 4;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_SILENT,
    CHK_FULL_PANEL
  } check_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] fore;
    logic [15:0] back;
    logic [7:0]  bits;
  } word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
    logic       done;
  } disp_byte_t;

  typedef struct packed {
    word_t  word;
    check_e chk;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_win_x;
  logic [7:0]  in_win_y;
  logic [7:0]  in_win_width;
  logic [7:0]  in_win_height;
  logic [15:0] in_fore_color;
  logic [15:0] in_back_color;
  logic [7:0]  in_bitmap_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_is_data;
  logic        out_last_of_run;
  logic        out_image_done;

  // Model state of the expander.
  logic        image_open;
  logic [15:0] pix_left;
  logic [15:0] hold_fore;
  logic [15:0] hold_back;
  logic [7:0]  col_off;
  logic [7:0]  row_off;

  disp_byte_t pending_bytes[$];
  dir_row_t   dir_rows[$];
  int         mismatches;
  int         idle_cycles;
  int         stall_left;
  logic       no_idle;

  one_bit_image_expander #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_win_x       (in_win_x),
    .in_win_y       (in_win_y),
    .in_win_width   (in_win_width),
    .in_win_height  (in_win_height),
    .in_fore_color  (in_fore_color),
    .in_back_color  (in_back_color),
    .in_bitmap_byte (in_bitmap_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_data    (out_is_data),
    .out_last_of_run(out_last_of_run),
    .out_image_done (out_image_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_exp(input logic [7:0] data, input logic is_data,
                                   input logic last, input logic done);
    disp_byte_t e;
    e.data    = data;
    e.is_data = is_data;
    e.last    = last;
    e.done    = done;
    pending_bytes.push_back(e);
  endfunction

  // Appends the display bytes that one accepted word produces.
  function automatic void expand_word(input word_t w);
    int          right;
    int          bottom;
    logic [15:0] colour;
    if (w.opcode == OP_BEGIN) begin
      image_open = 1'b0;
      right  = w.x + w.w - 1;
      bottom = w.y + w.h - 1;
      if (w.w == 0 || w.h == 0 || right >= PANEL_W || bottom >= PANEL_H) return;
      hold_fore  = w.fore;
      hold_back  = w.back;
      pix_left   = {8'h00, w.w} * {8'h00, w.h};
      image_open = 1'b1;
      push_exp(CMD_COLUMN_SET, 1'b0, 1'b0, 1'b0);
      push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
      push_exp(w.x + col_off, 1'b1, 1'b0, 1'b0);
      push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
      push_exp(w.x + w.w - 8'd1 + col_off, 1'b1, 1'b0, 1'b0);
      push_exp(CMD_ROW_SET, 1'b0, 1'b0, 1'b0);
      push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
      push_exp(w.y + row_off, 1'b1, 1'b0, 1'b0);
      push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
      push_exp(w.y + w.h - 8'd1 + row_off, 1'b1, 1'b0, 1'b0);
      push_exp(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
      return;
    end
    if (!image_open || pix_left == 0) begin
      image_open = 1'b0;
      return;
    end
    for (int k = 0; k < 8 && pix_left != 0; k++) begin
      colour = w.bits[k] ? hold_fore : hold_back;
      push_exp(colour[7:0], 1'b1, 1'b0, 1'b0);
      push_exp(colour[15:8], 1'b1, (k == 7) || (pix_left == 1), pix_left == 1);
      pix_left = pix_left - 16'd1;
    end
    if (pix_left == 0) image_open = 1'b0;
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.opcode = 1'($urandom_range(0, 1));
    w.x      = 8'($urandom_range(0, 255));
    w.y      = 8'($urandom_range(0, 255));
    w.w      = 8'($urandom_range(0, 255));
    w.h      = 8'($urandom_range(0, 255));
    w.fore   = 16'($urandom_range(0, 65535));
    w.back   = 16'($urandom_range(0, 65535));
    w.bits   = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic void add_row(input logic op, input logic [7:0] x, input logic [7:0] y,
                                  input logic [7:0] w, input logic [7:0] h,
                                  input logic [15:0] fore, input logic [15:0] back,
                                  input logic [7:0] bits, input check_e chk);
    dir_row_t r;
    r.word.opcode = op;
    r.word.x      = x;
    r.word.y      = y;
    r.word.w      = w;
    r.word.h      = h;
    r.word.fore   = fore;
    r.word.back   = back;
    r.word.bits   = bits;
    r.chk         = chk;
    dir_rows.push_back(r);
  endfunction

  // Presents one word, waits for it to be taken and predicts its bytes.
  task automatic send_word(input word_t w, output int produced);
    int gap;
    int mark;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= w.opcode;
    in_win_x       <= w.x;
    in_win_y       <= w.y;
    in_win_width   <= w.w;
    in_win_height  <= w.h;
    in_fore_color  <= w.fore;
    in_back_color  <= w.back;
    in_bitmap_byte <= w.bits;
    do @(posedge clk); while (!in_ready);
    mark = pending_bytes.size();
    expand_word(w);
    produced = pending_bytes.size() - mark;
  endtask

  task automatic drain_stream();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic set_offsets(input logic [7:0] col, input logic [7:0] row);
    drain_stream();
    // A silent word may still be in flight after the last byte drained.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLUMN_OFFSET;
    cfg_wdata <= col;
    @(posedge clk);
    col_off   = col;
    cfg_index <= CFG_ROW_OFFSET;
    cfg_wdata <= row;
    @(posedge clk);
    row_off   = row;
    cfg_we    <= 1'b0;
  endtask

  // Mostly complete images with random content; some are cut short, some
  // carry extra bytes, and the rest is rejected windows, stray bytes and random words.
  task automatic run_random(input int target);
    int    sent;
    int    got;
    int    kind;
    int    nbytes;
    word_t w;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      w    = random_word();
      if (kind < 72) begin
        w.opcode = OP_BEGIN;
        if ($urandom_range(0, 9) == 0) begin
          w.w = 8'($urandom_range(1, PANEL_W));
          w.h = 8'($urandom_range(1, 2));
        end else begin
          w.w = 8'($urandom_range(1, 8));
          w.h = 8'($urandom_range(1, 6));
        end
        w.x = 8'($urandom_range(0, PANEL_W - w.w));
        w.y = 8'($urandom_range(0, PANEL_H - w.h));
        if ($urandom_range(0, 39) == 0) drain_stream();
        send_word(w, got);
        sent++;
        nbytes = (int'(w.w) * int'(w.h) + 7) / 8;
        if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nbytes);
        else if ($urandom_range(0, 5) == 0) nbytes += $urandom_range(1, 2);
        for (int i = 0; i < nbytes; i++) begin
          w        = random_word();
          w.opcode = OP_BITMAP;
          send_word(w, got);
          sent++;
        end
      end else if (kind < 84) begin
        w.opcode = OP_BEGIN;
        case ($urandom_range(0, 3))
          0: w.w = 8'd0;
          1: w.h = 8'd0;
          2: w.x = 8'($urandom_range(PANEL_W, 255));
          default: w.y = 8'($urandom_range(PANEL_H, 255));
        endcase
        send_word(w, got);
        sent++;
      end else if (kind < 92) begin
        w.opcode = OP_BITMAP;
        send_word(w, got);
        sent++;
      end else begin
        send_word(w, got);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    disp_byte_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected word: byte %h is_data %b last %b done %b", $time,
                 out_byte, out_is_data, out_last_of_run, out_image_done);
        mismatches++;
      end else begin
        e = pending_bytes.pop_front();
        if (out_byte !== e.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, e.data, out_byte);
          mismatches++;
        end
        if (out_is_data !== e.is_data) begin
          $display("%0t: out_is_data expected %b actual %b", $time, e.is_data, out_is_data);
          mismatches++;
        end
        if (out_last_of_run !== e.last) begin
          $display("%0t: out_last_of_run expected %b actual %b", $time, e.last,
                   out_last_of_run);
          mismatches++;
        end
        if (out_image_done !== e.done) begin
          $display("%0t: out_image_done expected %b actual %b", $time, e.done,
                   out_image_done);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    int       got;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_COLUMN_OFFSET;
    cfg_wdata      = 8'h00;
    in_valid       = 1'b0;
    in_opcode      = OP_BEGIN;
    in_win_x       = 8'h00;
    in_win_y       = 8'h00;
    in_win_width   = 8'h00;
    in_win_height  = 8'h00;
    in_fore_color  = 16'h0000;
    in_back_color  = 16'h0000;
    in_bitmap_byte = 8'h00;
    out_ready      = 1'b0;
    stall_left     = 0;
    no_idle        = 1'b0;
    mismatches     = 0;
    idle_cycles    = 0;
    image_open     = 1'b0;
    pix_left       = 16'h0000;
    hold_fore      = 16'h0000;
    hold_back      = 16'h0000;
    col_off        = 8'h00;
    row_off        = 8'h00;

    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'hFF, CHK_SILENT);
    add_row(OP_BEGIN, 0, 0, 128, 160, 16'hFFFF, 16'h0000, 8'h00, CHK_FULL_PANEL);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'hFF, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h00, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'hA5, CHK_PREDICT);
    // Rejected windows close the open image and leave the colors alone.
    add_row(OP_BEGIN, 4, 4, 0, 5, 16'h1111, 16'h2222, 8'h00, CHK_SILENT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h3C, CHK_SILENT);
    add_row(OP_BEGIN, 4, 4, 5, 0, 16'h3333, 16'h4444, 8'h00, CHK_SILENT);
    add_row(OP_BEGIN, 127, 159, 1, 1, 16'h1234, 16'hABCD, 8'h00, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'hFE, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'hFF, CHK_SILENT);
    add_row(OP_BEGIN, 127, 0, 2, 1, 16'h5555, 16'h6666, 8'h00, CHK_SILENT);
    add_row(OP_BEGIN, 0, 159, 1, 2, 16'h7777, 16'h8888, 8'h00, CHK_SILENT);
    add_row(OP_BEGIN, 255, 255, 255, 255, 16'hFFFF, 16'hFFFF, 8'hFF, CHK_SILENT);
    add_row(OP_BEGIN, 10, 20, 3, 3, 16'h5A5A, 16'hA5A5, 8'h00, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h55, CHK_PREDICT);
    // A new window while one pixel of the old image is still owed.
    add_row(OP_BEGIN, 1, 2, 4, 2, 16'hF00F, 16'h0FF0, 8'h00, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h0F, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h01, CHK_SILENT);
    add_row(OP_BEGIN, 0, 0, 255, 255, 16'h0000, 16'h0000, 8'h00, CHK_SILENT);
    add_row(OP_BEGIN, 0, 0, 1, 1, 16'hFFFF, 16'h0000, 8'h00, CHK_PREDICT);
    add_row(OP_BITMAP, 0, 0, 0, 0, 16'h0000, 16'h0000, 8'h80, CHK_PREDICT);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      send_word(row.word, got);
      if (row.chk != CHK_PREDICT) begin
        repeat (got) pending_bytes.delete(pending_bytes.size() - 1);
      end
      if (row.chk == CHK_FULL_PANEL) begin
        push_exp(CMD_COLUMN_SET, 1'b0, 1'b0, 1'b0);
        push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
        push_exp(8'h00, 1'b1, 1'b0, 1'b0);
        push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
        push_exp(8'h7F, 1'b1, 1'b0, 1'b0);
        push_exp(CMD_ROW_SET, 1'b0, 1'b0, 1'b0);
        push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
        push_exp(8'h00, 1'b1, 1'b0, 1'b0);
        push_exp(ADDR_HIGH_BYTE, 1'b1, 1'b0, 1'b0);
        push_exp(8'h9F, 1'b1, 1'b0, 1'b0);
        push_exp(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_offsets(8'hFF, 8'hFF);
        1: set_offsets(8'h80, 8'h7F);
        2: set_offsets(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: set_offsets(8'h00, 8'hFF);
      endcase
      // The second phase runs with no gaps or stalls at all.
      no_idle = (ph == 1);
      run_random(RANDOM_WORDS / PHASES);
    end

    no_idle = 1'b0;
    drain_stream();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
